>>> src/lcr_pkg.sv
package lcr_pkg;

  // coordinate width and derived widths
  localparam int COORD_BITS = 12;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int CNT_BITS   = $clog2(COORD_BITS + 1);

  // clip rounds
  localparam int ROUND_BITS = 3;
  localparam logic [ROUND_BITS-1:0] MAX_ROUNDS = ROUND_BITS'(4);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEFT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_RIGHT  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_TOP    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_BOTTOM = CFG_IDX_BITS'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [3:0]                   code_t;

  // window reset values
  localparam coord_t WIN_LEFT_RST   = COORD_BITS'(200);
  localparam coord_t WIN_RIGHT_RST  = COORD_BITS'(400);
  localparam coord_t WIN_TOP_RST    = COORD_BITS'(250);
  localparam coord_t WIN_BOTTOM_RST = COORD_BITS'(400);

  // region code bits
  localparam code_t CODE_LEFT  = 4'd1;
  localparam code_t CODE_RIGHT = 4'd2;
  localparam code_t CODE_BELOW = 4'd4;
  localparam code_t CODE_ABOVE = 4'd8;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
    code_t  region_start;
    code_t  region_end;
    logic   fully_inside;
  } out_t;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [PROD_BITS-1:0]  dividend;
    logic [COORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [COORD_BITS-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_MUL,
    ST_DIVGO,
    ST_DIV
  } state_t;

  // region code of a point against an inclusive window
  function automatic code_t region_code(input coord_t x, input coord_t y,
                                        input coord_t l, input coord_t r,
                                        input coord_t t, input coord_t b);
    code_t c;
    c = '0;
    if (x < l) c = c | CODE_LEFT;
    if (x > r) c = c | CODE_RIGHT;
    if (y > b) c = c | CODE_BELOW;
    if (y < t) c = c | CODE_ABOVE;
    return c;
  endfunction

  // a - b, one bit wider
  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    diff_t ae;
    diff_t be;
    ae = {a[COORD_BITS-1], a};
    be = {b[COORD_BITS-1], b};
    return ae - be;
  endfunction

  // magnitude of a difference; always fits a coordinate width
  function automatic logic [COORD_BITS-1:0] mag(input diff_t v);
    logic [DIFF_BITS-1:0] n;
    n = v[DIFF_BITS-1] ? -v : v;
    return n[COORD_BITS-1:0];
  endfunction

endpackage

>>> src/lcr_div.sv
// Restoring divider, one quotient bit per cycle.
// The quotient must fit COORD_BITS bits (upper dividend half below divisor).
module lcr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lcr_pkg::div_req_t req,
  output lcr_pkg::div_rsp_t rsp
);

  localparam int CW = lcr_pkg::COORD_BITS;

  logic [CW-1:0]                rem_r, rem_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                dvs_r, dvs_nxt;
  logic [lcr_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CW:0]                  rem2;
  logic [CW:0]                  diff;
  logic                         ge;

  // one shift-subtract step
  assign rem2 = {rem_r, lo_r[CW-1]};
  assign ge   = rem2 >= {1'b0, dvs_r};
  assign diff = rem2 - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend[2*CW-1:CW];
      lo_nxt   = req.dividend[CW-1:0];
      dvs_nxt  = req.divisor;
      cnt_nxt  = lcr_pkg::CNT_BITS'(CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CW-1:0] : rem2[CW-1:0];
      lo_nxt  = {lo_r[CW-2:0], ge};
      cnt_nxt = cnt_r - lcr_pkg::CNT_BITS'(1);
      if (cnt_r == lcr_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = lo_r;

endmodule

>>> src/line_clip_rectangle.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_ready     | in_data (segment endpoints)
// out     | output    | out_valid / out_ready   | out_data (clipped segment, codes)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data (window edge)
//
// Each item takes 0 to 4 clip rounds; each round runs the serial divider, one quotient
// bit per cycle. The result is loaded as the sequencer returns to idle, so in_ready
// rises together with out_valid; loading waits while the previous result is unread.
// in_ready is high only while no item is in work; a new item may enter while the
// previous result waits on out_ready, but its result then waits for that one.
// Reset (rst_n low, synchronous) loads the default window and empties the block.
module line_clip_rectangle (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lcr_pkg::in_t                          in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lcr_pkg::out_t                         out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  lcr_pkg::coord_t                       cfg_data
);

  localparam int CW = lcr_pkg::COORD_BITS;
  localparam int DW = lcr_pkg::DIFF_BITS;

  lcr_pkg::state_t state_r, state_nxt;

  // window registers
  lcr_pkg::coord_t win_l_r, win_r_r, win_t_r, win_b_r;

  // segment under work
  lcr_pkg::coord_t x0_r, y0_r, x1_r, y1_r;
  lcr_pkg::coord_t x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  lcr_pkg::code_t  r0_r, r1_r, r0_nxt, r1_nxt;
  lcr_pkg::code_t  c0_r, c1_r, c0_nxt, c1_nxt;
  logic [lcr_pkg::ROUND_BITS-1:0] round_r, round_nxt;
  logic            empty_r, empty_nxt;
  logic            inside_r, inside_nxt;

  // clip round operands
  lcr_pkg::diff_t  d_r, t_r, den_r, d_nxt, t_nxt, den_nxt;
  lcr_pkg::coord_t base_r, edge_r, base_nxt, edge_nxt;
  logic            clip_y_r, clip_y_nxt;
  logic            move0_r, move0_nxt;
  logic [lcr_pkg::PROD_BITS-1:0] prod_r, prod_nxt;
  logic [CW-1:0]   den_mag_r, den_mag_nxt;
  logic            neg_r, neg_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  lcr_pkg::out_t   out_r, out_nxt;

  lcr_pkg::div_req_t div_req;
  lcr_pkg::div_rsp_t div_rsp;
  logic              div_start;

  lcr_pkg::code_t  c0_now, c1_now, csel;
  lcr_pkg::code_t  in_r0, in_r1;
  logic            decided, vis, can_load;
  logic [CW-1:0]   quo;
  logic [DW-1:0]   step_val;
  logic [DW-1:0]   new_val;
  lcr_pkg::coord_t new_c;

  lcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == lcr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // codes of the incoming endpoints and of the current ones
  assign in_r0  = lcr_pkg::region_code(in_data.start_x, in_data.start_y,
                                       win_l_r, win_r_r, win_t_r, win_b_r);
  assign in_r1  = lcr_pkg::region_code(in_data.end_x, in_data.end_y,
                                       win_l_r, win_r_r, win_t_r, win_b_r);
  assign c0_now = lcr_pkg::region_code(x0_r, y0_r, win_l_r, win_r_r, win_t_r, win_b_r);
  assign c1_now = lcr_pkg::region_code(x1_r, y1_r, win_l_r, win_r_r, win_t_r, win_b_r);

  assign vis      = !empty_r && ((c0_now | c1_now) == '0);
  assign decided  = empty_r || ((c0_now | c1_now) == '0) ||
                    ((c0_now & c1_now) != '0) || (round_r == lcr_pkg::MAX_ROUNDS);
  assign can_load = !out_valid_r || out_ready;
  assign csel     = (c0_r != '0) ? c0_r : c1_r;

  // signed quotient added to the base coordinate; zero divisor gives zero
  assign quo      = (den_mag_r == '0) ? '0 : div_rsp.quotient;
  assign step_val = neg_r ? -{1'b0, quo} : {1'b0, quo};
  assign new_val  = {base_r[CW-1], base_r} + step_val;
  assign new_c    = new_val[CW-1:0];

  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = prod_r;
    div_req.divisor  = den_mag_r;
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    round_nxt     = round_r;
    empty_nxt     = empty_r;
    inside_nxt    = inside_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    den_nxt       = den_r;
    base_nxt      = base_r;
    edge_nxt      = edge_r;
    clip_y_nxt    = clip_y_r;
    move0_nxt     = move0_r;
    prod_nxt      = prod_r;
    den_mag_nxt   = den_mag_r;
    neg_nxt       = neg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      lcr_pkg::ST_IDLE: begin
        if (in_valid) begin
          x0_nxt     = in_data.start_x;
          y0_nxt     = in_data.start_y;
          x1_nxt     = in_data.end_x;
          y1_nxt     = in_data.end_y;
          r0_nxt     = in_r0;
          r1_nxt     = in_r1;
          round_nxt  = '0;
          empty_nxt  = (win_l_r > win_r_r) || (win_t_r > win_b_r);
          inside_nxt = !((win_l_r > win_r_r) || (win_t_r > win_b_r)) &&
                       (in_r0 == '0) && (in_r1 == '0);
          state_nxt  = lcr_pkg::ST_CHECK;
        end
      end

      // accept, reject or start another round
      lcr_pkg::ST_CHECK: begin
        if (decided) begin
          if (can_load) begin
            out_nxt.visible      = vis;
            out_nxt.clip_start_x = vis ? x0_r : '0;
            out_nxt.clip_start_y = vis ? y0_r : '0;
            out_nxt.clip_end_x   = vis ? x1_r : '0;
            out_nxt.clip_end_y   = vis ? y1_r : '0;
            out_nxt.region_start = r0_r;
            out_nxt.region_end   = r1_r;
            out_nxt.fully_inside = inside_r;
            out_valid_nxt        = 1'b1;
            state_nxt            = lcr_pkg::ST_IDLE;
          end
        end else begin
          c0_nxt    = c0_now;
          c1_nxt    = c1_now;
          state_nxt = lcr_pkg::ST_SETUP;
        end
      end

      // pick the edge and form the deltas
      lcr_pkg::ST_SETUP: begin
        move0_nxt = (c0_r != '0);
        if ((csel & lcr_pkg::CODE_ABOVE) != '0 || (csel & lcr_pkg::CODE_BELOW) != '0) begin
          clip_y_nxt = 1'b1;
          edge_nxt   = ((csel & lcr_pkg::CODE_ABOVE) != '0) ? win_t_r : win_b_r;
          base_nxt   = x0_r;
          d_nxt      = lcr_pkg::sub_ext(x1_r, x0_r);
          t_nxt      = lcr_pkg::sub_ext(((csel & lcr_pkg::CODE_ABOVE) != '0) ?
                                        win_t_r : win_b_r, y0_r);
          den_nxt    = lcr_pkg::sub_ext(y1_r, y0_r);
        end else begin
          clip_y_nxt = 1'b0;
          edge_nxt   = ((csel & lcr_pkg::CODE_RIGHT) != '0) ? win_r_r : win_l_r;
          base_nxt   = y0_r;
          d_nxt      = lcr_pkg::sub_ext(y1_r, y0_r);
          t_nxt      = lcr_pkg::sub_ext(((csel & lcr_pkg::CODE_RIGHT) != '0) ?
                                        win_r_r : win_l_r, x0_r);
          den_nxt    = lcr_pkg::sub_ext(x1_r, x0_r);
        end
        state_nxt = lcr_pkg::ST_MUL;
      end

      // magnitude product and sign
      lcr_pkg::ST_MUL: begin
        prod_nxt    = lcr_pkg::PROD_BITS'(lcr_pkg::mag(d_r)) *
                      lcr_pkg::PROD_BITS'(lcr_pkg::mag(t_r));
        den_mag_nxt = lcr_pkg::mag(den_r);
        neg_nxt     = d_r[DW-1] ^ t_r[DW-1] ^ den_r[DW-1];
        state_nxt   = lcr_pkg::ST_DIVGO;
      end

      lcr_pkg::ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = lcr_pkg::ST_DIV;
      end

      // move the chosen endpoint onto the edge
      lcr_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (move0_r) begin
            x0_nxt = clip_y_r ? new_c : edge_r;
            y0_nxt = clip_y_r ? edge_r : new_c;
          end else begin
            x1_nxt = clip_y_r ? new_c : edge_r;
            y1_nxt = clip_y_r ? edge_r : new_c;
          end
          round_nxt = round_r + lcr_pkg::ROUND_BITS'(1);
          state_nxt = lcr_pkg::ST_CHECK;
        end
      end

      default: begin
        state_nxt = lcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      round_r     <= '0;
      win_l_r     <= lcr_pkg::WIN_LEFT_RST;
      win_r_r     <= lcr_pkg::WIN_RIGHT_RST;
      win_t_r     <= lcr_pkg::WIN_TOP_RST;
      win_b_r     <= lcr_pkg::WIN_BOTTOM_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      round_r     <= round_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lcr_pkg::REG_WIN_LEFT:   win_l_r <= cfg_data;
          lcr_pkg::REG_WIN_RIGHT:  win_r_r <= cfg_data;
          lcr_pkg::REG_WIN_TOP:    win_t_r <= cfg_data;
          lcr_pkg::REG_WIN_BOTTOM: win_b_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    c0_r      <= c0_nxt;
    c1_r      <= c1_nxt;
    empty_r   <= empty_nxt;
    inside_r  <= inside_nxt;
    d_r       <= d_nxt;
    t_r       <= t_nxt;
    den_r     <= den_nxt;
    base_r    <= base_nxt;
    edge_r    <= edge_nxt;
    clip_y_r  <= clip_y_nxt;
    move0_r   <= move0_nxt;
    prod_r    <= prod_nxt;
    den_mag_r <= den_mag_nxt;
    neg_r     <= neg_nxt;
    out_r     <= out_nxt;
  end

  // divider finishes only while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == lcr_pkg::ST_DIV)
    else $error("divider done outside wait state");

  a_wait_has_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcr_pkg::ST_DIV |-> div_rsp.busy || div_rsp.done)
    else $error("waiting on an idle divider");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lcr_pkg::ST_CHECK |-> round_r <= lcr_pkg::MAX_ROUNDS)
    else $error("clip round count out of range");

  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.visible |->
      out_r.clip_start_x == '0 && out_r.clip_start_y == '0 &&
      out_r.clip_end_x == '0 && out_r.clip_end_y == '0)
    else $error("rejected segment carries coordinates");

  a_inside_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fully_inside |-> out_r.visible)
    else $error("inside segment reported invisible");

endmodule

>>> sim/line_clip_rectangle_chk.sv
`timescale 1ns / 100ps

// Watches the three channels of line_clip_rectangle, predicts each clipped
// segment when the item is accepted and compares results in arrival order.
module line_clip_rectangle_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  lcr_pkg::in_t                    in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  lcr_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lcr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  lcr_pkg::coord_t                 cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  localparam int CLIP_ROUNDS = 4;

  // window copy, held wide so edge arithmetic never wraps
  longint clip_left;
  longint clip_right;
  longint clip_top;
  longint clip_bottom;

  lcr_pkg::out_t clipped_q[$];
  lcr_pkg::out_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_failure(input string msg);
    $display("chk: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] exp_val);
    if (got !== exp_val)
      report_failure($sformatf("result %0d: %s is %0d, predicted %0d",
                               checked, name, got, exp_val));
  endtask

  function automatic lcr_pkg::code_t outcode(input longint x, input longint y);
    lcr_pkg::code_t c;
    c = '0;
    if (x < clip_left)   c = c | lcr_pkg::CODE_LEFT;
    if (x > clip_right)  c = c | lcr_pkg::CODE_RIGHT;
    if (y > clip_bottom) c = c | lcr_pkg::CODE_BELOW;
    if (y < clip_top)    c = c | lcr_pkg::CODE_ABOVE;
    return c;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // trunc(d * t / den) in sign-magnitude form; zero divisor gives 0
  function automatic longint scaled_offset(input longint d, input longint t,
                                           input longint den);
    longint q;
    bit     neg;
    if (den == 0) return 0;
    q   = (magnitude(d) * magnitude(t)) / magnitude(den);
    neg = ((d < 0) != (t < 0)) != (den < 0);
    if (d == 0 || t == 0) neg = 1'b0;
    return neg ? -q : q;
  endfunction

  // Cohen-Sutherland against the inclusive window
  function automatic lcr_pkg::out_t clip_segment(input lcr_pkg::in_t seg);
    longint         x0, y0, x1, y1, nx, ny;
    lcr_pkg::code_t r0, r1, c0, c1, c;
    bit             empty, vis, all_in, done;
    int             rnd;
    lcr_pkg::out_t  res;
    x0 = longint'(seg.start_x);
    y0 = longint'(seg.start_y);
    x1 = longint'(seg.end_x);
    y1 = longint'(seg.end_y);
    r0 = outcode(x0, y0);
    r1 = outcode(x1, y1);
    c0 = r0;
    c1 = r1;
    empty  = (clip_left > clip_right) || (clip_top > clip_bottom);
    vis    = 1'b0;
    all_in = !empty && r0 == '0 && r1 == '0;
    done   = empty;
    rnd    = 0;
    while (!done) begin
      if ((c0 | c1) == '0) begin
        vis  = 1'b1;
        done = 1'b1;
      end else if ((c0 & c1) != '0 || rnd == CLIP_ROUNDS) begin
        done = 1'b1;
      end else begin
        // move one outside endpoint: above, below, right, left
        c = (c0 != '0) ? c0 : c1;
        if ((c & lcr_pkg::CODE_ABOVE) != '0) begin
          ny = clip_top;
          nx = x0 + scaled_offset(x1 - x0, clip_top - y0, y1 - y0);
        end else if ((c & lcr_pkg::CODE_BELOW) != '0) begin
          ny = clip_bottom;
          nx = x0 + scaled_offset(x1 - x0, clip_bottom - y0, y1 - y0);
        end else if ((c & lcr_pkg::CODE_RIGHT) != '0) begin
          nx = clip_right;
          ny = y0 + scaled_offset(y1 - y0, clip_right - x0, x1 - x0);
        end else begin
          nx = clip_left;
          ny = y0 + scaled_offset(y1 - y0, clip_left - x0, x1 - x0);
        end
        if (c == c0) begin
          x0 = nx;
          y0 = ny;
          c0 = outcode(x0, y0);
        end else begin
          x1 = nx;
          y1 = ny;
          c1 = outcode(x1, y1);
        end
        rnd++;
      end
    end
    if (!vis) begin
      x0 = 0;
      y0 = 0;
      x1 = 0;
      y1 = 0;
    end
    res.visible      = vis;
    res.clip_start_x = x0[lcr_pkg::COORD_BITS-1:0];
    res.clip_start_y = y0[lcr_pkg::COORD_BITS-1:0];
    res.clip_end_x   = x1[lcr_pkg::COORD_BITS-1:0];
    res.clip_end_y   = y1[lcr_pkg::COORD_BITS-1:0];
    res.region_start = r0;
    res.region_end   = r1;
    res.fully_inside = all_in;
    return res;
  endfunction

  // all handshakes sampled at the rising edge, before the edge's updates land
  always @(posedge clk) begin
    if (!rst_n) begin
      clip_left   = longint'(lcr_pkg::WIN_LEFT_RST);
      clip_right  = longint'(lcr_pkg::WIN_RIGHT_RST);
      clip_top    = longint'(lcr_pkg::WIN_TOP_RST);
      clip_bottom = longint'(lcr_pkg::WIN_BOTTOM_RST);
      clipped_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lcr_pkg::REG_WIN_LEFT:   clip_left   = longint'(cfg_data);
          lcr_pkg::REG_WIN_RIGHT:  clip_right  = longint'(cfg_data);
          lcr_pkg::REG_WIN_TOP:    clip_top    = longint'(cfg_data);
          lcr_pkg::REG_WIN_BOTTOM: clip_bottom = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        clipped_q.push_back(clip_segment(in_data));
        pending++;
      end
      if (out_valid && out_ready) begin
        if (clipped_q.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no segment waiting",
                                   checked));
        end else begin
          want = clipped_q.pop_front();
          pending--;
          check_field("visible", 32'(out_data.visible), 32'(want.visible));
          check_field("clip_start_x", 32'(out_data.clip_start_x),
                      32'(want.clip_start_x));
          check_field("clip_start_y", 32'(out_data.clip_start_y),
                      32'(want.clip_start_y));
          check_field("clip_end_x", 32'(out_data.clip_end_x), 32'(want.clip_end_x));
          check_field("clip_end_y", 32'(out_data.clip_end_y), 32'(want.clip_end_y));
          check_field("region_start", 32'(out_data.region_start),
                      32'(want.region_start));
          check_field("region_end", 32'(out_data.region_end), 32'(want.region_end));
          check_field("fully_inside", 32'(out_data.fully_inside),
                      32'(want.fully_inside));
        end
        checked++;
      end
    end
  end

endmodule

>>> sim/line_clip_rectangle_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for line_clip_rectangle; checking is in the checker.
module line_clip_rectangle_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_IDLE    = 12;
  localparam int PHASES      = 12;
  localparam int FIXED_WINS  = 8;
  localparam int PHASE_ITEMS = 145;
  localparam int C_MIN       = -2048;
  localparam int C_MAX       = 2047;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  lcr_pkg::in_t                     in_data;
  logic                             out_valid;
  logic                             out_ready;
  lcr_pkg::out_t                    out_data;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lcr_pkg::CFG_IDX_BITS-1:0] cfg_index;
  lcr_pkg::coord_t                  cfg_data;

  int fail_count;
  int pending;
  int checked;
  int unsigned cycle_count = 0;
  int segs_sent = 0;
  int windows_used = 1;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  // window the block holds now, as written
  int wl = 200;
  int wr = 400;
  int wt = 250;
  int wb = 400;

  // fixed window settings: reset, full range, empty in x, empty in y,
  // single point, line on the left extreme, far corner, off-center box
  int fix_l[FIXED_WINS] = '{200, -2048, 500, -300, 37, -2048, 2047, -1000};
  int fix_r[FIXED_WINS] = '{400, 2047, 100, 300, 37, -2048, 2047, -10};
  int fix_t[FIXED_WINS] = '{250, -2048, -100, 900, -5, -2048, 2047, 5};
  int fix_b[FIXED_WINS] = '{400, 2047, 300, -900, -5, 2047, 2047, 1500};

  line_clip_rectangle dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_clip_rectangle_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // low coordinate bits of an integer
  function automatic lcr_pkg::coord_t to_coord(input int v);
    return v[lcr_pkg::COORD_BITS-1:0];
  endfunction

  // random coordinate in [lo - m, hi + m], kept in range
  function automatic int near(input int lo, input int hi, input int m);
    int a;
    int b;
    a = (lo - m < C_MIN) ? C_MIN : lo - m;
    b = (hi + m > C_MAX) ? C_MAX : hi + m;
    return rand_between(a, b);
  endfunction

  // random segment, mostly around the current window
  function automatic lcr_pkg::in_t pick_segment();
    int           lo_x, hi_x, lo_y, hi_y, m, kind;
    lcr_pkg::in_t seg;
    lo_x = (wl < wr) ? wl : wr;
    hi_x = (wl < wr) ? wr : wl;
    lo_y = (wt < wb) ? wt : wb;
    hi_y = (wt < wb) ? wb : wt;
    m    = $urandom_range(0, 300);
    kind = $urandom_range(0, 99);
    seg.start_x = to_coord(near(lo_x, hi_x, m));
    seg.start_y = to_coord(near(lo_y, hi_y, m));
    seg.end_x   = to_coord(near(lo_x, hi_x, m));
    seg.end_y   = to_coord(near(lo_y, hi_y, m));
    if (kind < 15) begin
      // anywhere in the coordinate range
      seg.start_x = to_coord(int'($urandom));
      seg.start_y = to_coord(int'($urandom));
      seg.end_x   = to_coord(int'($urandom));
      seg.end_y   = to_coord(int'($urandom));
    end else if (kind < 25) begin
      // vertical or horizontal
      if ($urandom_range(0, 1)) seg.end_x = seg.start_x;
      else seg.end_y = seg.start_y;
    end else if (kind < 35) begin
      // endpoints pinned to window edges
      seg.start_x = to_coord($urandom_range(0, 1) ? lo_x : hi_x);
      seg.end_y   = to_coord($urandom_range(0, 1) ? lo_y : hi_y);
    end else if (kind < 50) begin
      // one endpoint inside, the other anywhere
      seg.start_x = to_coord(near(lo_x, hi_x, 0));
      seg.start_y = to_coord(near(lo_y, hi_y, 0));
      seg.end_x   = to_coord(int'($urandom));
      seg.end_y   = to_coord(int'($urandom));
      if ($urandom_range(0, 1)) seg = {seg.end_x, seg.end_y, seg.start_x, seg.start_y};
    end
    return seg;
  endfunction

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_segment(input lcr_pkg::in_t seg);
    int gap;
    gap = idle_cycles(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    segs_sent++;
  endtask

  task automatic send_points(input int sx, input int sy, input int ex, input int ey);
    lcr_pkg::in_t seg;
    seg.start_x = sx[lcr_pkg::COORD_BITS-1:0];
    seg.start_y = sy[lcr_pkg::COORD_BITS-1:0];
    seg.end_x   = ex[lcr_pkg::COORD_BITS-1:0];
    seg.end_y   = ey[lcr_pkg::COORD_BITS-1:0];
    send_segment(seg);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // valid stays high across back-to-back register writes
  task automatic write_reg(input logic [lcr_pkg::CFG_IDX_BITS-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[lcr_pkg::COORD_BITS-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_window(input int l, input int r, input int t, input int b);
    write_reg(lcr_pkg::REG_WIN_LEFT, l);
    write_reg(lcr_pkg::REG_WIN_RIGHT, r);
    write_reg(lcr_pkg::REG_WIN_TOP, t);
    write_reg(lcr_pkg::REG_WIN_BOTTOM, b);
    cfg_valid <= 1'b0;
    wl = l;
    wr = r;
    wt = t;
    wb = b;
    windows_used++;
  endtask

  // random edge pair: mostly ordered, sometimes narrow, sometimes reversed
  task automatic pick_span(output int lo, output int hi);
    int a;
    int b;
    a = rand_between(C_MIN, C_MAX);
    if ($urandom_range(0, 3) == 0) b = rand_between(a, (a + 40 > C_MAX) ? C_MAX : a + 40);
    else b = rand_between(C_MIN, C_MAX);
    if (a > b && $urandom_range(0, 5) != 0) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
  endtask

  // result side: random stall before each result
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_cycles(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int l, r, t, b;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lcr_pkg::REG_WIN_LEFT;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed segments against the reset window
    send_points(250, 300, 350, 350);      // both inside
    send_points(200, 250, 400, 400);      // corners, edges inclusive
    send_points(100, 300, 300, 300);      // horizontal, start left
    send_points(300, 0, 300, 1000);       // vertical through top and bottom
    send_points(-500, 300, 1000, 300);    // horizontal through both sides
    send_points(100, 100, 500, 100);      // both above: trivial reject
    send_points(0, 0, 100, 1000);         // both left: trivial reject
    send_points(0, 300, 300, 0);          // misses the corner after rounds
    send_points(-2048, -2048, 2047, 2047);
    send_points(-2048, 2047, 2047, -2048);
    send_points(300, 300, 300, 300);      // single point inside
    send_points(0, 0, 0, 0);              // single point outside
    send_points(300, 300, 1000, 1000);    // end clipped
    send_points(300, 300, -2048, 300);
    send_points(2047, 2047, 2047, 2047);
    send_points(-2048, -2048, -2048, -2048);
    send_points(300, 300, 350, 2000);     // end below
    send_points(150, 200, 450, 450);      // both endpoints clipped
    drain();

    // random segments over a series of windows and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      if (p < FIXED_WINS) begin
        write_window(fix_l[p], fix_r[p], fix_t[p], fix_b[p]);
      end else begin
        pick_span(l, r);
        pick_span(t, b);
        write_window(l, r, t, b);
      end
      tx_calm = (p % 4 == 1) || (p % 4 == 3);
      rx_calm = (p % 4 == 2) || (p % 4 == 3);
      repeat (PHASE_ITEMS) send_segment(pick_segment());
      drain();
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (100) @(posedge clk);
    $display("summary: %0d segments clipped across %0d window settings",
             segs_sent, windows_used);
    $display("summary: %0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> line_clip_rectangle.f
src/lcr_pkg.sv
src/lcr_div.sv
src/line_clip_rectangle.sv
sim/line_clip_rectangle_chk.sv
sim/line_clip_rectangle_tb.sv
